@@ src/rmc_pkg.sv @@
package rmc_pkg;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FUNC_READ_COILS = 8'h01;
    localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
    localparam logic [7:0]  BROADCAST_ADDR  = 8'hFF;
    localparam logic [7:0]  ADDR_RESET      = 8'h04;
    localparam logic [7:0]  READ_BYTE_COUNT = 8'h01;
    localparam int          MIN_FRAME       = 8;
    localparam int          HDR_DEPTH       = 6;

    // request handed from front to back
    typedef struct packed {
        logic       is_write;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEND   = 4'b0010,
        ST_CRC_LO = 4'b0100,
        ST_CRC_HI = 4'b1000
    } tx_state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/rmc_fifo.sv @@
module rmc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rmc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output rmc_pkg::cmd_t head_cmd,
    output logic          empty,
    output logic          full
);

    rmc_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/rmc_front.sv @@
module rmc_front #(
    parameter int MAX_FRAME = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    rx_byte,
    input  logic          frame_end,
    input  logic [7:0]    slave_address,
    output logic          push,
    output rmc_pkg::cmd_t push_cmd
);

    localparam int CW = $clog2(MAX_FRAME + 2);

    logic [CW-1:0] count_reg, count_next, n_val;
    logic [15:0]   crc_reg, crc_next, crc_upd;
    logic [15:0]   tail_reg, tail_next;
    logic [7:0]    hdr_reg [rmc_pkg::HDR_DEPTH];
    logic [15:0]   rx_crc;
    logic          len_ok, addr_ok, crc_ok, start_zero;
    logic          is_write, is_read;

    always_comb
    begin
        n_val = (count_reg <= CW'(MAX_FRAME)) ? count_reg + CW'(1) : count_reg;
        crc_upd = crc_reg;
        if (n_val >= CW'(3) && n_val <= CW'(MAX_FRAME))
        begin
            crc_upd = rmc_pkg::crc_byte(crc_reg, tail_reg[15:8]);
        end
        rx_crc     = {rx_byte, tail_reg[7:0]};
        len_ok     = (n_val >= CW'(rmc_pkg::MIN_FRAME)) && (n_val <= CW'(MAX_FRAME));
        addr_ok    = (hdr_reg[0] == slave_address) || (hdr_reg[0] == rmc_pkg::BROADCAST_ADDR);
        crc_ok     = (rx_crc == crc_upd);
        start_zero = ({hdr_reg[2], hdr_reg[3]} == 16'h0000);
        is_write   = (hdr_reg[1] == rmc_pkg::FUNC_WRITE_COIL) && start_zero;
        is_read    = (hdr_reg[1] == rmc_pkg::FUNC_READ_COILS);

        push              = in_fire && frame_end && len_ok && addr_ok && crc_ok
                            && (is_write || is_read);
        push_cmd.is_write = is_write;
        push_cmd.b2       = hdr_reg[2];
        push_cmd.b3       = hdr_reg[3];
        push_cmd.b4       = hdr_reg[4];
        push_cmd.b5       = hdr_reg[5];

        count_next = count_reg;
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        if (in_fire)
        begin
            if (frame_end)
            begin
                count_next = '0;
                crc_next   = rmc_pkg::CRC_INIT;
                tail_next  = 16'h0000;
            end
            else
            begin
                count_next = n_val;
                crc_next   = crc_upd;
                tail_next  = {tail_reg[7:0], rx_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= rmc_pkg::CRC_INIT;
            tail_reg  <= 16'h0000;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
        end
    end

    // header capture, first six bytes of the frame
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < rmc_pkg::HDR_DEPTH; i++)
        begin
            if (in_fire && n_val == CW'(i + 1))
            begin
                hdr_reg[i] <= rx_byte;
            end
        end
    end

endmodule

@@ src/rmc_back.sv @@
module rmc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    slave_address,
    input  rmc_pkg::cmd_t head_cmd,
    input  logic          empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic          m_tlast
);

    rmc_pkg::tx_state_t state_reg, state_next;
    logic [7:0]  msg_reg [rmc_pkg::HDR_DEPTH];
    logic [7:0]  msg_next [rmc_pkg::HDR_DEPTH];
    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  last_idx_reg, last_idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  coil_reg, coil_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  ocoil_reg, ocoil_next;
    logic        last_reg, last_next;
    logic        advance, load;
    logic [15:0] start, qty;
    logic [7:0]  shifted, mask, rd_data;
    logic [8:0]  mask_w;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {ocoil_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign pop      = load;

    always_comb
    begin
        start   = {head_cmd.b2, head_cmd.b3};
        qty     = {head_cmd.b4, head_cmd.b5};
        shifted = (start[15:3] == 13'd0) ? (coil_reg >> start[2:0]) : 8'h00;
        mask_w  = (9'd1 << qty[3:0]) - 9'd1;
        mask    = (qty > 16'd8) ? 8'hFF : mask_w[7:0];
        rd_data = shifted & mask;

        state_next    = state_reg;
        msg_next      = msg_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        crc_next      = crc_reg;
        coil_next     = coil_reg;
        valid_next    = advance ? 1'b0 : valid_reg;
        byte_next     = byte_reg;
        ocoil_next    = ocoil_reg;
        last_next     = last_reg;
        load          = 1'b0;

        case (state_reg)
            rmc_pkg::ST_IDLE:
            begin
                load = !empty;
            end
            rmc_pkg::ST_SEND:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    byte_next  = msg_reg[idx_reg];
                    ocoil_next = coil_reg;
                    last_next  = 1'b0;
                    crc_next   = rmc_pkg::crc_byte(crc_reg, msg_reg[idx_reg]);
                    idx_next   = idx_reg + 3'd1;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = rmc_pkg::ST_CRC_LO;
                    end
                end
            end
            rmc_pkg::ST_CRC_LO:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    byte_next  = crc_reg[7:0];
                    ocoil_next = coil_reg;
                    last_next  = 1'b0;
                    state_next = rmc_pkg::ST_CRC_HI;
                end
            end
            rmc_pkg::ST_CRC_HI:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    byte_next  = crc_reg[15:8];
                    ocoil_next = coil_reg;
                    last_next  = 1'b1;
                    state_next = rmc_pkg::ST_IDLE;
                    load       = !empty;
                end
            end
            default:
            begin
                state_next = rmc_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            state_next  = rmc_pkg::ST_SEND;
            idx_next    = 3'd0;
            crc_next    = rmc_pkg::CRC_INIT;
            msg_next[0] = slave_address;
            if (head_cmd.is_write)
            begin
                coil_next[0]  = (qty != 16'h0000);
                msg_next[1]   = rmc_pkg::FUNC_WRITE_COIL;
                msg_next[2]   = head_cmd.b2;
                msg_next[3]   = head_cmd.b3;
                msg_next[4]   = head_cmd.b4;
                msg_next[5]   = head_cmd.b5;
                last_idx_next = 3'd5;
            end
            else
            begin
                msg_next[1]   = rmc_pkg::FUNC_READ_COILS;
                msg_next[2]   = rmc_pkg::READ_BYTE_COUNT;
                msg_next[3]   = rd_data;
                last_idx_next = 3'd3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmc_pkg::ST_IDLE;
            coil_reg  <= 8'h00;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            coil_reg  <= coil_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg      <= msg_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        crc_reg      <= crc_next;
        byte_reg     <= byte_next;
        ocoil_reg    <= ocoil_next;
        last_reg     <= last_next;
    end

endmodule

@@ src/modbus_rtu_coil_slave.sv @@
// channel | dir | tdata                     | tlast
// s_axis  | in  | [7:0] rx_byte             | frame_end
// m_axis  | out | [7:0] tx_byte, [15:8] coil | tx_last
// cfg     | in  | cfg_wdata = slave_address | -
//
// one received byte accepted per cycle while the request queue has a free slot; frame check finishes on the last byte
// a valid request queues to the reply side, which sends one byte per cycle while m_tready holds
// a reply is 8 bytes (write coil) or 6 bytes (read coils), crc low byte first
// s_tready drops only while both request queue slots are taken
// reset clears coils to off, address to 4, frame state to empty
module modbus_rtu_coil_slave #(
    parameter int MAX_FRAME = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [15:8] coil_bits
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]    addr_reg;
    logic          in_fire, push, pop, empty, full;
    rmc_pkg::cmd_t push_cmd, head_cmd;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= rmc_pkg::ADDR_RESET;
        end
        else if (cfg_we)
        begin
            addr_reg <= cfg_wdata;
        end
    end

    rmc_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .rx_byte      (s_tdata),
        .frame_end    (s_tlast),
        .slave_address(addr_reg),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    rmc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .empty   (empty),
        .full    (full)
    );

    rmc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .slave_address(addr_reg),
        .head_cmd     (head_cmd),
        .empty        (empty),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

@@ src/rmc_checker.sv @@
module rmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled reply word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled reply word changed");

    // only coil 0 can ever be set
    a_upper_coils: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("upper coil bit set");

    // coil state constant within one reply
    a_coil_steady: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || m_tdata[15:8] == $past(m_tdata[15:8]))
        else $error("coil bits changed inside a reply");

endmodule

bind modbus_rtu_coil_slave rmc_checker u_rmc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
